@@ rtl/sorted_array_priority_queue_defines.svh @@
// assertion macros for the sorted array priority queue
// no dependencies; included by modules that carry assertions
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define SAPQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sapq: same-cycle check failed");
`define SAPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sapq: next-cycle check failed");
`else
`define SAPQ_ASSERT_IMPL(label, ante, cons)
`define SAPQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/sapq_pkg.sv @@
// shared types and codes for the sorted array priority queue
// no dependencies
package sapq_pkg;

    localparam int DEPTH_DEFAULT       = 16;
    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int FUNC_W              = 2;
    localparam int STATUS_W            = 2;
    localparam int CAP_W               = 5;
    localparam int DATA_W              = 32;
    localparam int PADDR_W             = 3;
    localparam int PDATA_W             = 32;

    localparam logic [CAP_W-1:0]   CAPACITY_RESET = 5'd16;
    localparam logic [PADDR_W-1:0] ADDR_CAPACITY  = 3'd0;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LIST   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_ROTATE = 2'd2
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LIST = 2'b10
    } state_t;

endpackage

@@ rtl/sapq_cell.sv @@
// one slot of the sorted chain: holds an entry, compares and shifts
// depends on sapq_pkg
module sapq_cell
    import sapq_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
    parameter int CNT_W       = 5,
    parameter int INDEX       = 0
)
(
    input  logic                   clk,
    input  cell_op_t               op,
    input  logic [CNT_W-1:0]       count,
    input  logic [VALUE_WIDTH-1:0] ins_value,
    input  logic [VALUE_WIDTH-1:0] head_value,
    input  logic [VALUE_WIDTH-1:0] left_data,
    input  logic                   left_ge,
    input  logic [VALUE_WIDTH-1:0] right_data,
    output logic [VALUE_WIDTH-1:0] data,
    output logic                   ge
);

    logic [VALUE_WIDTH-1:0] data_reg;
    logic [VALUE_WIDTH-1:0] data_next;
    logic                   occupied;
    logic                   is_last;

    // empty slots count as larger than any value
    assign occupied = CNT_W'(INDEX) < count;
    assign is_last  = CNT_W'(INDEX + 1) == count;
    assign ge       = !occupied || ($signed(data_reg) > $signed(ins_value));
    assign data     = data_reg;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            OP_INSERT:
            begin
                if (left_ge)
                begin
                    data_next = left_data;
                end
                else if (ge)
                begin
                    data_next = ins_value;
                end
            end
            OP_ROTATE:
            begin
                if (is_last)
                begin
                    data_next = head_value;
                end
                else if (occupied)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

@@ rtl/sorted_array_priority_queue.sv @@
// top level of the sorted array priority queue: control, output register, apb port
// depends on sapq_pkg, sapq_cell and sorted_array_priority_queue_defines.svh
//
//   port group   direction  handshake            payload
//   in           sink       in_valid / in_ready   func, value
//   out          source     out_valid / out_ready result_value, status, last
//   apb          slave      psel, penable, pready paddr, pwdata, prdata
//
// insert and delete: every cell compares and shifts at once
// list gives one result per held entry, read from the head as the chain rotates (a single empty result when empty)
// the output register lets the next transaction in while the current result is taken
// reset clears the count and state; capacity resets to 16; cell contents are left as they are
`include "sorted_array_priority_queue_defines.svh"

module sorted_array_priority_queue
    import sapq_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [FUNC_W-1:0]   func,
    input  logic [DATA_W-1:0]   value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [DATA_W-1:0]   result_value,
    output logic [STATUS_W-1:0] status,
    output logic                last,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    state_t                 state_reg;
    state_t                 state_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       idx_next;
    logic [CAP_W-1:0]       capacity_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [DATA_W-1:0]      result_value_reg;
    logic [DATA_W-1:0]      result_value_next;
    logic [STATUS_W-1:0]    status_reg;
    logic [STATUS_W-1:0]    status_next;
    logic                   last_reg;
    logic                   last_next;

    logic                   slot_free;
    logic                   in_fire;
    logic                   full;
    logic                   empty;
    cell_op_t               op;
    logic [VALUE_WIDTH-1:0] ins_value;
    logic [DATA_W-1:0]      head_out;
    logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
    logic                   cell_ge   [DEPTH];

    // input and output width adaptation
    generate
        if (VALUE_WIDTH > DATA_W)
        begin : g_wide
            assign ins_value = {{(VALUE_WIDTH - DATA_W){value[DATA_W-1]}}, value};
            assign head_out  = cell_data[0][DATA_W-1:0];
        end
        else if (VALUE_WIDTH == DATA_W)
        begin : g_equal
            assign ins_value = value;
            assign head_out  = cell_data[0];
        end
        else
        begin : g_narrow
            assign ins_value = value[VALUE_WIDTH-1:0];
            assign head_out  = {{(DATA_W - VALUE_WIDTH){cell_data[0][VALUE_WIDTH-1]}},
                                cell_data[0]};
        end
    endgenerate

    // the chain of cells
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] left_data;
            logic                   left_ge;
            logic [VALUE_WIDTH-1:0] right_data;

            if (gi == 0)
            begin : g_first
                assign left_data = ins_value;
                assign left_ge   = 1'b0;
            end
            else
            begin : g_mid
                assign left_data = cell_data[gi-1];
                assign left_ge   = cell_ge[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_end
                assign right_data = cell_data[gi];
            end
            else
            begin : g_inner
                assign right_data = cell_data[gi+1];
            end

            sapq_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .CNT_W       (CNT_W),
                .INDEX       (gi)
            ) u_cell (
                .clk        (clk),
                .op         (op),
                .count      (count_reg),
                .ins_value  (ins_value),
                .head_value (cell_data[0]),
                .left_data  (left_data),
                .left_ge    (left_ge),
                .right_data (right_data),
                .data       (cell_data[gi]),
                .ge         (cell_ge[gi])
            );
        end
    endgenerate

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign in_fire   = in_valid && in_ready;
    assign empty     = count_reg == '0;
    assign full      = (count_reg >= CNT_W'(DEPTH)) ||
                       (CMP_W'(count_reg) >= CMP_W'(capacity_reg));

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        op                = OP_HOLD;
        out_valid_next    = out_valid_reg && !out_ready;
        result_value_next = result_value_reg;
        status_next       = status_reg;
        last_next         = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (func)
                        FUNC_INSERT:
                        begin
                            out_valid_next    = 1'b1;
                            result_value_next = '0;
                            last_next         = 1'b1;
                            if (full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                status_next = STATUS_OK;
                                op          = OP_INSERT;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        FUNC_DELETE:
                        begin
                            out_valid_next = 1'b1;
                            last_next      = 1'b1;
                            if (empty)
                            begin
                                status_next       = STATUS_EMPTY;
                                result_value_next = '0;
                            end
                            else
                            begin
                                // head moves behind the rest and drops out of the count
                                status_next       = STATUS_OK;
                                result_value_next = head_out;
                                op                = OP_ROTATE;
                                count_next        = count_reg - 1'b1;
                            end
                        end
                        FUNC_LIST:
                        begin
                            if (empty)
                            begin
                                out_valid_next    = 1'b1;
                                status_next       = STATUS_EMPTY;
                                result_value_next = '0;
                                last_next         = 1'b1;
                            end
                            else
                            begin
                                state_next = S_LIST;
                                idx_next   = '0;
                            end
                        end
                        default:
                        begin
                            op = OP_HOLD;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (slot_free)
                begin
                    // a full rotation leaves the order unchanged
                    out_valid_next    = 1'b1;
                    status_next       = STATUS_OK;
                    result_value_next = head_out;
                    last_next         = (idx_reg + 1'b1) == count_reg;
                    op                = OP_ROTATE;
                    idx_next          = idx_reg + 1'b1;
                    if ((idx_reg + 1'b1) == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_value_reg <= result_value_next;
        status_reg       <= status_next;
        last_reg         <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;
    assign last         = last_reg;

    // register port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_CAPACITY[2]))
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == ADDR_CAPACITY[2])
        begin
            prdata = {{(PDATA_W - CAP_W){1'b0}}, capacity_reg};
        end
    end

    `SAPQ_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `SAPQ_ASSERT_IMPL(a_list_nonempty, state_reg == S_LIST, count_reg != '0)
    `SAPQ_ASSERT_NEXT(a_insert_grows, in_fire && func == FUNC_INSERT && !full, count_reg == $past(count_reg) + 1'b1)
    `SAPQ_ASSERT_NEXT(a_list_ends, state_reg == S_LIST && slot_free && last_next, state_reg == S_IDLE && last_reg)

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking bench for sorted_array_priority_queue: directed and random transactions
// a sorted-queue tracker predicts every result; depends on sapq_pkg and the dut only

import sapq_pkg::*;

class pq_tracker;
    typedef struct packed {
        logic [DATA_W-1:0]   val;
        logic [STATUS_W-1:0] st;
        logic                lst;
    } pq_result_t;

    logic signed [DATA_W-1:0] held[$];
    pq_result_t               owed[$];
    int unsigned              limit;
    int                       errors;

    function new();
        limit  = 16;
        errors = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
        limit = (c > 16) ? 16 : c;
    endfunction

    function void owe(logic [DATA_W-1:0] v, logic [STATUS_W-1:0] s, logic l);
        pq_result_t r;
        r.val = v;
        r.st  = s;
        r.lst = l;
        owed.push_back(r);
    endfunction

    function int pending();
        return owed.size();
    endfunction

    function int fill();
        return held.size();
    endfunction

    function void note_request(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] v);
        int pos;
        case (f)
            FUNC_INSERT:
                if (held.size() >= limit) begin
                    owe('0, STATUS_FULL, 1'b1);
                end
                else begin
                    pos = held.size();
                    for (int i = 0; i < held.size(); i++) begin
                        if (held[i] > $signed(v)) begin
                            pos = i;
                            break;
                        end
                    end
                    held.insert(pos, v);
                    owe('0, STATUS_OK, 1'b1);
                end
            FUNC_DELETE:
                if (held.size() == 0)
                    owe('0, STATUS_EMPTY, 1'b1);
                else
                    owe(held.pop_front(), STATUS_OK, 1'b1);
            FUNC_LIST:
                if (held.size() == 0) begin
                    owe('0, STATUS_EMPTY, 1'b1);
                end
                else begin
                    foreach (held[i])
                        owe(held[i], STATUS_OK, i == held.size() - 1);
                end
            default: ;
        endcase
    endfunction

    function void check_result(logic [DATA_W-1:0] v, logic [STATUS_W-1:0] s, logic l);
        pq_result_t e;
        if (owed.size() == 0) begin
            $error("result with nothing outstanding: value %0d status %0d last %0b",
                   $signed(v), s, l);
            errors++;
            return;
        end
        e = owed.pop_front();
        if (v !== e.val) begin
            $error("result_value: expected %0d, got %0d", $signed(e.val), $signed(v));
            errors++;
        end
        if (s !== e.st) begin
            $error("status: expected %0d, got %0d", e.st, s);
            errors++;
        end
        if (l !== e.lst) begin
            $error("last: expected %0b, got %0b", e.lst, l);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_ITEMS    = 25;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [FUNC_W-1:0]   func = '0;
    logic [DATA_W-1:0]   value = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [DATA_W-1:0]   result_value;
    logic [STATUS_W-1:0] status;
    logic                last;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    pq_tracker sb;
    bit        gaps_on = 1'b0;
    bit        hold_off_req = 1'b0;
    int        idle_cycles = 0;

    sorted_array_priority_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .status       (status),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic push_op(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        sb.note_request(f, v);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CAPACITY;
        pwdata  <= {{(PDATA_W-CAP_W){1'b0}}, c};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_capacity(c);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        if (r < 4)
            return $urandom_range(0, 16) - 8;
        return $urandom;
    endfunction

    task automatic random_op(input int ins_pct);
        int r;
        logic [FUNC_W-1:0] f;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            f = FUNC_INSERT;
        else if (r < 88)
            f = FUNC_DELETE;
        else if (r < 96)
            f = FUNC_LIST;
        else
            f = FUNC_UNUSED;
        push_op(f, pick_value());
    endtask

    // output side
    initial
    begin
        int gap;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(result_value, status, last);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [CAP_W-1:0] caps[8];
        int               ins[8];
        caps = '{5'd31, 5'd17, 5'd3, 5'd0, 5'd1, 5'd16, 5'd8, 5'd31};
        ins  = '{75, 75, 40, 40, 50, 70, 30, 60};
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue, extremes, ties, unused code, list and delete
        push_op(FUNC_DELETE, 32'h1234_5678);
        push_op(FUNC_LIST, 32'h0);
        push_op(FUNC_INSERT, 32'h7fff_ffff);
        push_op(FUNC_INSERT, 32'h8000_0000);
        push_op(FUNC_INSERT, 32'h0000_0000);
        push_op(FUNC_INSERT, 32'hffff_ffff);
        push_op(FUNC_INSERT, 32'd5);
        push_op(FUNC_INSERT, 32'd5);
        push_op(FUNC_INSERT, 32'h8000_0000);
        push_op(FUNC_UNUSED, 32'hdead_beef);
        push_op(FUNC_LIST, 32'hffff_ffff);
        push_op(FUNC_DELETE, 32'h0);
        push_op(FUNC_DELETE, 32'h0);
        push_op(FUNC_LIST, 32'h0);
        push_op(FUNC_INSERT, 32'h0000_0001);
        push_op(FUNC_DELETE, 32'h0);
        push_op(FUNC_LIST, 32'h0);

        for (int p = 0; p < 8; p++)
        begin
            drain();
            write_capacity(caps[p]);
            gaps_on = (p != 4);
            // long output stall while the sender keeps offering transactions
            if (p == 1)
                hold_off_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_op(ins[p]);
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
